### sv/mvt_pkg.sv
// Shared constants and types of the 4x4 matrix-vector transform.
`default_nettype none

package mvt_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int DIM        = 4;
  localparam int FIELD_W    = 32;
  localparam int NUM_PAIRS  = 8;
  localparam int PAIR_W     = 2 * FIELD_W;
  localparam int PAIR_IDX_W = $clog2(NUM_PAIRS);

  // Identity matrix: 1.0 at entries 0, 5, 10 and 15.
  localparam logic [PAIR_W-1:0] PAIR_RESET [NUM_PAIRS] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };

  typedef struct packed {
    logic mul;
    logic add;
    logic sum;
    logic fin;
  } adv_t;

endpackage

`default_nettype wire

### sv/mvt_lane.sv
// One result component: four products, adder tree, shift and saturation.
`default_nettype none

module mvt_lane #(
  parameter int DATA_WIDTH = mvt_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mvt_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire mvt_pkg::adv_t                adv,
  input  wire logic signed [DATA_WIDTH-1:0] vec  [mvt_pkg::DIM],
  input  wire logic signed [DATA_WIDTH-1:0] coef [mvt_pkg::DIM],
  output logic        [mvt_pkg::FIELD_W-1:0] res,
  output logic                               sat
);

  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam logic signed [SUM_W-1:0] MAXV =
    SUM_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] MINV = -MAXV - SUM_W'(1);

  logic signed [PROD_W-1:0]     prod [mvt_pkg::DIM];
  logic signed [PAIR_W-1:0]     pair_lo;
  logic signed [PAIR_W-1:0]     pair_hi;
  logic signed [SUM_W-1:0]      total;
  logic signed [SUM_W-1:0]      shifted;
  logic signed [DATA_WIDTH-1:0] clamp;
  logic                         clamp_hit;

  always_ff @(posedge clk) begin
    if (adv.mul) begin
      for (int k = 0; k < mvt_pkg::DIM; k++) begin
        prod[k] <= vec[k] * coef[k];
      end
    end
    if (adv.add) begin
      pair_lo <= PAIR_W'(prod[0]) + PAIR_W'(prod[1]);
      pair_hi <= PAIR_W'(prod[2]) + PAIR_W'(prod[3]);
    end
    if (adv.sum) begin
      total <= SUM_W'(pair_lo) + SUM_W'(pair_hi);
    end
  end

  always_comb begin
    shifted = total >>> FRAC_BITS;
    priority if (shifted > MAXV) begin
      clamp     = MAXV[DATA_WIDTH-1:0];
      clamp_hit = 1'b1;
    end else if (shifted < MINV) begin
      clamp     = MINV[DATA_WIDTH-1:0];
      clamp_hit = 1'b1;
    end else begin
      clamp     = shifted[DATA_WIDTH-1:0];
      clamp_hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.fin) begin
      res <= mvt_pkg::FIELD_W'(clamp);
      sat <= clamp_hit;
    end
  end

endmodule

`default_nettype wire

### sv/matrix_vector_transform.sv
// Top level of the 4x4 matrix-vector transform in signed fixed point.
//
//   Channel   Direction  Signals                          Content
//   s_axis    in         s_tvalid s_tready s_tdata        one input vector
//   m_axis    out        m_tvalid m_tready m_tdata m_tuser one result vector
//   config    in         wr_en wr_index wr_data           matrix entry pairs
//
// One item enters per cycle while the output is not stalled; a result passes from the
// input register through the multiply, pair add, final add, shift and clamp stages.
// Each stage moves on when the stage after it is empty or moving, so a stall
// on the output only fills bubbles and loses nothing.
// Reset empties the pipeline and loads the identity matrix.
`default_nettype none

module matrix_vector_transform #(
  parameter int DATA_WIDTH = mvt_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mvt_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // vec_x [31:0], vec_y [63:32], vec_z [95:64], vec_w [127:96]
  input  wire logic [mvt_pkg::DIM*mvt_pkg::FIELD_W-1:0] s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // out_x [31:0], out_y [63:32], out_z [95:64], out_w [127:96]
  output logic [mvt_pkg::DIM*mvt_pkg::FIELD_W-1:0] m_tdata,
  // saturated [0]
  output logic                                   m_tuser,
  input  wire logic                              wr_en,
  input  wire logic [mvt_pkg::PAIR_IDX_W-1:0]    wr_index,
  input  wire logic [mvt_pkg::PAIR_W-1:0]        wr_data
);

  localparam int DIM = mvt_pkg::DIM;
  localparam int FW  = mvt_pkg::FIELD_W;

  logic [mvt_pkg::PAIR_W-1:0]   matrix [mvt_pkg::NUM_PAIRS];
  logic signed [DATA_WIDTH-1:0] coef   [DIM][DIM];
  logic signed [DATA_WIDTH-1:0] vec    [DIM];
  logic [DIM-1:0]               lane_sat;

  logic v_in, v_mul, v_add, v_sum;
  logic rdy_in, rdy_mul, rdy_add, rdy_sum, rdy_out;
  mvt_pkg::adv_t adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < mvt_pkg::NUM_PAIRS; p++) begin
        matrix[p] <= mvt_pkg::PAIR_RESET[p];
      end
    end else if (wr_en) begin
      matrix[wr_index] <= wr_data;
    end
  end

  for (genvar i = 0; i < DIM; i++) begin : g_row
    for (genvar k = 0; k < DIM; k++) begin : g_col
      localparam int E = DIM * k + i;
      assign coef[i][k] = matrix[E / 2][(E % 2) * FW +: DATA_WIDTH];
    end
  end

  assign rdy_out = !m_tvalid || m_tready;
  assign rdy_sum = !v_sum || rdy_out;
  assign rdy_add = !v_add || rdy_sum;
  assign rdy_mul = !v_mul || rdy_add;
  assign rdy_in  = !v_in  || rdy_mul;
  assign s_tready = rdy_in;

  assign adv.mul = rdy_mul;
  assign adv.add = rdy_add;
  assign adv.sum = rdy_sum;
  assign adv.fin = rdy_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in     <= 1'b0;
      v_mul    <= 1'b0;
      v_add    <= 1'b0;
      v_sum    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (rdy_in)  v_in     <= s_tvalid;
      if (rdy_mul) v_mul    <= v_in;
      if (rdy_add) v_add    <= v_mul;
      if (rdy_sum) v_sum    <= v_add;
      if (rdy_out) m_tvalid <= v_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_in) begin
      for (int k = 0; k < DIM; k++) begin
        vec[k] <= s_tdata[k*FW +: DATA_WIDTH];
      end
    end
  end

  for (genvar i = 0; i < DIM; i++) begin : g_lane
    mvt_lane #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .adv  (adv),
      .vec  (vec),
      .coef (coef[i]),
      .res  (m_tdata[i*FW +: FW]),
      .sat  (lane_sat[i])
    );
  end

  assign m_tuser = |lane_sat;

  a_ready_if_room: assert property (@(posedge clk) disable iff (rst)
    !(v_in && v_mul && v_add && v_sum && m_tvalid) |-> s_tready)
    else $error("input refused while the pipeline has an empty stage");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> v_in)
    else $error("accepted item did not reach the input register");

  a_sum_held: assert property (@(posedge clk) disable iff (rst)
    v_sum && !rdy_sum |=> v_sum)
    else $error("stalled item lost from the final add stage");

  a_mul_held: assert property (@(posedge clk) disable iff (rst)
    v_mul && !rdy_mul |=> v_mul)
    else $error("stalled item lost from the multiply stage");

endmodule

`default_nettype wire
